// ----- rtl/core/tfp_pkg.sv -----
// Package for the RGBA to texel format packer.
// Holds the payload structs, the configuration struct and the format and register codes.
// No dependencies.
package tfp_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned FmtW      = 3;
  localparam int unsigned RowWidthW = 13;

  typedef enum logic [FmtW-1:0] {
    FMT_RGBA32   = 3'd0,
    FMT_RGBA5551 = 3'd1,
    FMT_I4       = 3'd2,
    FMT_I8       = 3'd3,
    FMT_IA4      = 3'd4,
    FMT_IA8      = 3'd5,
    FMT_IA16     = 3'd6
  } fmt_e;

  typedef enum logic {
    REG_TEXEL_FORMAT = 1'b0,
    REG_ROW_WIDTH    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       image_start;
  } pixel_t;

  typedef struct packed {
    logic [31:0] packed_data;
    logic [2:0]  byte_count;
  } texel_t;

  typedef struct packed {
    logic [FmtW-1:0]      texel_format;
    logic [RowWidthW-1:0] row_width;
  } cfg_t;

endpackage

// ----- rtl/core/tfp_cfg_regs.sv -----
// Configuration register file of the texel format packer, on an APB-style port.
// Depends on tfp_pkg for the register codes and the configuration struct.
module tfp_cfg_regs
  import tfp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [FmtW-1:0]      texel_format_q, texel_format_d;
  logic [RowWidthW-1:0] row_width_q, row_width_d;
  logic                 wr_en;
  reg_idx_e             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    texel_format_d = texel_format_q;
    row_width_d    = row_width_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TEXEL_FORMAT: texel_format_d = pwdata[FmtW-1:0];
        REG_ROW_WIDTH:    row_width_d    = pwdata[RowWidthW-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      texel_format_q <= FmtW'(FMT_RGBA32);
      row_width_q    <= RowWidthW'(1);
    end else begin
      texel_format_q <= texel_format_d;
      row_width_q    <= row_width_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXEL_FORMAT: prdata = DataW'(texel_format_q);
      REG_ROW_WIDTH:    prdata = DataW'(row_width_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.texel_format = texel_format_q;
  assign cfg_o.row_width    = row_width_q;

endmodule

// ----- rtl/core/tfp_pack.sv -----
// Packing logic of the texel format packer: column tracking, nibble pairing and
// the per-format bit packing. Depends on tfp_pkg.
module tfp_pack
  import tfp_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  pixel_t pixel_i,
  input  cfg_t   cfg_i,
  output logic   res_valid_o,
  output texel_t res_o
);

  localparam int unsigned ColW = (MAX_ROW_WIDTH > 2) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned CmpW = ((ColW > RowWidthW) ? ColW : RowWidthW) + 1;

  logic [ColW-1:0] column_q, column_d, col_cur;
  logic [3:0]      held_q, held_d, held_cur;
  logic [CmpW-1:0] rw_ext, w_eff, col_next;
  logic            last, a_set;
  logic [3:0]      nib;
  logic [31:0]     data;
  logic [2:0]      count;

  // An image start clears the column and any held nibble before the pixel is used.
  assign col_cur  = pixel_i.image_start ? '0 : column_q;
  assign held_cur = pixel_i.image_start ? '0 : held_q;

  always_comb begin
    rw_ext = CmpW'(cfg_i.row_width);
    if (rw_ext == '0) begin
      w_eff = CmpW'(1);
    end else if (rw_ext > CmpW'(MAX_ROW_WIDTH)) begin
      w_eff = CmpW'(MAX_ROW_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
  end

  assign col_next = CmpW'(col_cur) + CmpW'(1);
  assign last     = (col_next >= w_eff);
  assign a_set    = (pixel_i.alpha != 8'd0);
  assign nib      = (cfg_i.texel_format == FMT_I4) ? pixel_i.red[7:4]
                                                   : {pixel_i.red[7:5], a_set};

  always_comb begin
    data   = '0;
    count  = 3'd0;
    held_d = 4'd0;
    unique case (cfg_i.texel_format)
      FMT_I4, FMT_IA4: begin
        if (!col_cur[0]) begin
          // The last pixel of an odd-width row closes its byte with a zero low nibble.
          if (last) begin
            data  = {24'd0, nib, 4'd0};
            count = 3'd1;
          end else begin
            held_d = nib;
          end
        end else begin
          data  = {24'd0, held_cur, nib};
          count = 3'd1;
        end
      end
      FMT_RGBA32: begin
        data  = {pixel_i.red, pixel_i.green, pixel_i.blue, pixel_i.alpha};
        count = 3'd4;
      end
      FMT_RGBA5551: begin
        data  = {16'd0, pixel_i.red[7:3], pixel_i.green[7:3], pixel_i.blue[7:3], a_set};
        count = 3'd2;
      end
      FMT_I8: begin
        data  = {24'd0, pixel_i.red};
        count = 3'd1;
      end
      FMT_IA8: begin
        data  = {24'd0, pixel_i.red[7:4], pixel_i.alpha[7:4]};
        count = 3'd1;
      end
      FMT_IA16: begin
        data  = {16'd0, pixel_i.red, pixel_i.alpha};
        count = 3'd2;
      end
      default: ;
    endcase
  end

  assign column_d = last ? '0 : col_next[ColW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      held_q   <= '0;
    end else if (step_i) begin
      column_q <= column_d;
      held_q   <= held_d;
    end
  end

  assign res_valid_o       = (count != 3'd0);
  assign res_o.packed_data = data;
  assign res_o.byte_count  = count;

endmodule

// ----- rtl/core/rgba_to_texel_format_packer_unit.sv -----
// RGBA to texel format packer, top level. A pixel is taken into the input register, then
// packed into the result register. Throughput: one pixel per cycle while the result
// register is empty or drained, set by the single packing stage between the two registers.
// i4/ia4 give one result per pixel pair or odd row-end pixel; a reserved one gives none.
// Reset (rst_ni, asynchronous, active low) empties both registers, clears the column
// and held nibble, and sets the format to rgba32 and the row width to one.
module rgba_to_texel_format_packer_unit
  import tfp_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pixel_t           in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output texel_t           out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t   cfg;
  logic   in_valid_q, in_valid_d;
  pixel_t in_data_q;
  logic   out_valid_q, out_valid_d;
  texel_t out_data_q;
  logic   advance, res_valid;
  texel_t res;

  tfp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held transaction moves on whenever the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  tfp_pack #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .pixel_i     (in_data_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
